// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the escape parser; included by aetp_parser.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define AETP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define AETP_ASSERT_IMP(lbl, ante, cons, msg) \
  `AETP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define AETP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `AETP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/aetp_pkg.sv =====
// Types and character constants of the escape sequence parser.
// No dependencies; used by every module of the block.
`default_nettype none

package aetp_pkg;

  typedef enum logic [2:0] {
    ACT_EMIT   = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_NORMAL = 3'd2,
    ACT_BOLD   = 3'd3,
    ACT_COLOR  = 3'd4
  } action_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_NBSP   = 8'hA0;
  localparam logic [7:0] CH_CSI    = 8'h9B;
  localparam logic [7:0] CH_OSC    = 8'h9D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SGR    = 8'h6D;

  localparam int unsigned PARAM_W = 16;
  localparam logic [PARAM_W-1:0] PARAM_MAX   = 16'hFFFF;
  localparam logic [PARAM_W-1:0] SGR_RESET   = 16'd0;
  localparam logic [PARAM_W-1:0] SGR_BOLD    = 16'd1;
  localparam logic [PARAM_W-1:0] SGR_FG_BLK  = 16'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_RED  = 16'd31;
  localparam logic [PARAM_W-1:0] SGR_FG_CYAN = 16'd36;
  localparam logic [PARAM_W-1:0] SGR_FG_WHT  = 16'd37;
  localparam logic [PARAM_W-1:0] SGR_FG_DEF  = 16'd39;

  localparam logic [2:0] COLOR_BLACK = 3'd0;

  // Character handed from the input register to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
  } step_t;

  // Parser result handed to the output register.
  typedef struct packed {
    logic       valid;
    action_e    action;
    logic [7:0] char_out;
    logic [2:0] color;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/aetp_in_if.sv =====
// Input channel of the escape parser: one Latin-1 character per item.
// No dependencies.
`default_nettype none

interface aetp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/aetp_out_if.sv =====
// Output channel of the escape parser: one display action per item.
// No dependencies.
`default_nettype none

interface aetp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_out;
  logic [2:0] color;

  modport source (output valid, output action, output char_out, output color, input ready);
  modport sink (input valid, input action, input char_out, input color, output ready);
endinterface

`default_nettype wire

// ===== rtl/aetp_in_reg.sv =====
// Input register of the escape parser: captures one character per item.
// Depends on aetp_pkg and aetp_in_if.
`default_nettype none

module aetp_in_reg
  import aetp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  aetp_in_if.sink    in_i,
  input  wire logic  advance_i,
  output step_t      step_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       take;

  // Accept when empty or when the held item moves on this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= in_i.char_code;
    end
  end

  assign step_o.valid     = valid_q && advance_i;
  assign step_o.char_code = char_q;

endmodule

`default_nettype wire

// ===== rtl/aetp_parser.sv =====
// Escape sequence state and per-character decode of the parser.
// Depends on aetp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module aetp_parser
  import aetp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  step_t     step_i,
  output result_t   res_o
);

  logic               esc_q, esc_d;
  logic               csi_q, csi_d;
  logic               osc_q, osc_d;
  logic               sep_q, sep_d;
  logic [PARAM_W-1:0] param_q, param_d;
  logic               present_q, present_d;

  logic [7:0]         c;
  logic               is_digit;
  logic               is_final;
  logic [PARAM_W+3:0] acc;
  logic [PARAM_W-1:0] color_off;

  assign c         = step_i.char_code;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  // base * 10 + digit; an absent parameter is already zero
  assign acc       = ({4'd0, param_q} << 3) + ({4'd0, param_q} << 1)
                   + {{PARAM_W{1'b0}}, 4'(c - CH_ZERO)};
  assign color_off = param_q - SGR_FG_BLK;

  always_comb begin
    esc_d     = esc_q;
    csi_d     = csi_q;
    osc_d     = osc_q;
    sep_d     = sep_q;
    param_d   = param_q;
    present_d = present_q;
    is_final  = 1'b0;
    res_o     = '{valid: 1'b0, action: ACT_EMIT, char_out: 8'd0, color: COLOR_BLACK};

    if (esc_q) begin
      if (csi_q || osc_q) begin
        priority if (is_digit) begin
          if (sep_q) begin
            param_d   = (acc[PARAM_W+3:PARAM_W] != 4'd0) ? PARAM_MAX : acc[PARAM_W-1:0];
            present_d = 1'b1;
          end
        end else if (c == CH_SEMI) begin
          sep_d = 1'b1;
        end else if (osc_q && (c == CH_BEL)) begin
          is_final = 1'b1;
        end else if (csi_q) begin
          is_final = (c != CH_NUL);
        end else begin
          // OSC body: drop
        end
      end else begin
        priority if (c == CH_LBRACK) begin
          csi_d = 1'b1;
        end else if (c == CH_RBRACK) begin
          osc_d = 1'b1;
        end else if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
          // character set selection: drop
        end else begin
          is_final = (c != CH_NUL);
        end
      end

      if (is_final) begin
        esc_d     = 1'b0;
        csi_d     = 1'b0;
        osc_d     = 1'b0;
        sep_d     = 1'b0;
        param_d   = '0;
        present_d = 1'b0;
        if (c == CH_SGR) begin
          priority if (!present_q) begin
            res_o.valid  = 1'b1;
            res_o.action = ACT_COLOR;
          end else if (param_q == SGR_RESET) begin
            res_o.valid  = 1'b1;
            res_o.action = ACT_NORMAL;
          end else if (param_q == SGR_BOLD) begin
            res_o.valid  = 1'b1;
            res_o.action = ACT_BOLD;
          end else if ((param_q >= SGR_FG_RED) && (param_q <= SGR_FG_CYAN)) begin
            res_o.valid  = 1'b1;
            res_o.action = ACT_COLOR;
            res_o.color  = color_off[2:0];
          end else if ((param_q == SGR_FG_BLK) || (param_q == SGR_FG_WHT) ||
                       (param_q == SGR_FG_DEF)) begin
            res_o.valid  = 1'b1;
            res_o.action = ACT_COLOR;
          end else begin
            // unsupported attribute: no item
          end
        end
      end
    end else begin
      priority if (c == CH_CR) begin
        res_o.valid    = 1'b1;
        res_o.char_out = CH_LF;
      end else if (((c >= CH_SPACE) && (c <= CH_TILDE)) || (c >= CH_NBSP) || (c == CH_LF)) begin
        res_o.valid    = 1'b1;
        res_o.char_out = c;
      end else if ((c == CH_DEL) || (c == CH_BS)) begin
        res_o.valid  = 1'b1;
        res_o.action = ACT_DELETE;
      end else if (c == CH_ESC) begin
        esc_d = 1'b1;
      end else if (c == CH_CSI) begin
        esc_d = 1'b1;
        csi_d = 1'b1;
      end else if (c == CH_OSC) begin
        esc_d = 1'b1;
        osc_d = 1'b1;
      end else begin
        // other controls: drop
      end
    end

    // Hold state and suppress the result when no character moves.
    if (!step_i.valid) begin
      esc_d       = esc_q;
      csi_d       = csi_q;
      osc_d       = osc_q;
      sep_d       = sep_q;
      param_d     = param_q;
      present_d   = present_q;
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q     <= 1'b0;
      csi_q     <= 1'b0;
      osc_q     <= 1'b0;
      sep_q     <= 1'b0;
      param_q   <= '0;
      present_q <= 1'b0;
    end else begin
      esc_q     <= esc_d;
      csi_q     <= csi_d;
      osc_q     <= osc_d;
      sep_q     <= sep_d;
      param_q   <= param_d;
      present_q <= present_d;
    end
  end

  `AETP_ASSERT(a_csi_osc_excl, !(csi_q && osc_q), "CSI and OSC active together")
  `AETP_ASSERT_IMP(a_sub_needs_esc, csi_q || osc_q, esc_q, "CSI/OSC without escape")
  `AETP_ASSERT_IMP(a_param_after_sep, present_q, sep_q && (csi_q || osc_q),
                   "parameter present outside a separated sequence")
  `AETP_ASSERT_IMP(a_absent_is_zero, !present_q, param_q == '0,
                   "absent parameter holds a value")
  `AETP_ASSERT_IMP(a_result_clean, res_o.valid && (res_o.action != ACT_EMIT),
                   res_o.char_out == 8'd0, "non-emit item carries a character")
  `AETP_ASSERT_NEXT(a_final_clears, res_o.valid && (res_o.action != ACT_EMIT) &&
                    (res_o.action != ACT_DELETE), !esc_q && !present_q,
                    "sequence state survives a final character")

endmodule

`default_nettype wire

// ===== rtl/aetp_out_reg.sv =====
// Output register of the escape parser: holds one result item until taken.
// Depends on aetp_pkg and aetp_out_if.
`default_nettype none

module aetp_out_reg
  import aetp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  result_t    res_i,
  output logic       free_o,
  aetp_out_if.source out_o
);

  logic       valid_q;
  action_e    action_q;
  logic [7:0] char_q;
  logic [2:0] color_q;

  // Load a new result once the held one is gone or leaves now.
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.valid) begin
      action_q <= res_i.action;
      char_q   <= res_i.char_out;
      color_q  <= res_i.color;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.action   = action_q;
  assign out_o.char_out = char_q;
  assign out_o.color    = color_q;

endmodule

`default_nettype wire

// ===== rtl/ansi_escape_text_parser.sv =====
// Top level of the ANSI/VT100 escape sequence parser.
// Depends on aetp_pkg, aetp_in_if, aetp_out_if, aetp_in_reg, aetp_parser, aetp_out_reg.
//
//   channel  dir  payload                         per item
//   in_i     in   char_code[7:0]                  one Latin-1 character
//   out_o    out  action[2:0] char_out[7:0] color[2:0]  zero or one per character
//
// One character per cycle while out_o is not stalled; a character waits in the input register,
// then is decoded into the output register, from which its result leaves.
// Reset clears the sequence state and both stage valids; no clearing pass.
// A stalled output holds the input register; in_i.ready drops only when both are full.

`default_nettype none

module ansi_escape_text_parser
  import aetp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  aetp_in_if.sink    in_i,
  aetp_out_if.source out_o
);

  step_t   step;
  result_t res;
  logic    free;

  aetp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (free),
    .step_o    (step)
  );

  aetp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  aetp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
